>>> design/kcq_pkg.sv
// kcq_pkg: widths, codes, state type and the scan token type
// shared by the keyed circular queue, its cells and its channel interfaces.
// No dependencies.
package kcq_pkg;

	// Payload widths
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned KEY_W   = 56;
	localparam int unsigned PRICE_W = 32;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned SLOT_W  = 3;
	localparam int unsigned TOTAL_W = 35;
	localparam int unsigned OCC_W   = 4;

	// Depth range and the token widths that cover all of it
	localparam int unsigned DEPTH_DEF = 8;
	localparam int unsigned DEPTH_MAX = 32;
	localparam int unsigned TIDX_W    = $clog2(DEPTH_MAX);
	localparam int unsigned SUM_W     = PRICE_W + $clog2(DEPTH_MAX);

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ  = 3'd0,
		CMD_DEQ  = 3'd1,
		CMD_MAX  = 3'd2,
		CMD_TOT  = 3'd3,
		CMD_SRCH = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STS_OK    = 3'd0,
		STS_FULL  = 3'd1,
		STS_EMPTY = 3'd2,
		STS_DUP   = 3'd3,
		STS_NONE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Token that walks the cell row, one cell per cycle
	typedef struct packed {
		logic                 found;       // key match seen
		logic [TIDX_W-1:0]    found_idx;   // lowest matching slot
		logic                 best_vld;    // a best/picked entry seen
		logic [TIDX_W-1:0]    best_idx;
		logic [KEY_W-1:0]     best_key;
		logic [PRICE_W-1:0]   best_price;
		logic [SUM_W-1:0]     sum;         // running price sum
	} scan_t;

endpackage

>>> design/kcq_cmd_if.sv
// kcq_cmd_if: command channel (valid/ready plus command payload).
// Depends on kcq_pkg.
interface kcq_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [kcq_pkg::CMD_W-1:0]     command;
	logic [kcq_pkg::KEY_W-1:0]     key_in;
	logic [kcq_pkg::PRICE_W-1:0]   price_in;

	modport source (output valid, command, key_in, price_in, input ready);
	modport sink   (input valid, command, key_in, price_in, output ready);
endinterface

>>> design/kcq_res_if.sv
// kcq_res_if: result channel (valid/ready plus result payload).
// Depends on kcq_pkg.
interface kcq_res_if;
	logic                          valid;
	logic                          ready;
	logic [kcq_pkg::STAT_W-1:0]    status;
	logic [kcq_pkg::SLOT_W-1:0]    slot;
	logic [kcq_pkg::KEY_W-1:0]     key_out;
	logic [kcq_pkg::PRICE_W-1:0]   price_out;
	logic [kcq_pkg::TOTAL_W-1:0]   total_out;
	logic [kcq_pkg::OCC_W-1:0]     occupancy;

	modport source (output valid, status, slot, key_out, price_out, total_out, occupancy,
		input ready);
	modport sink   (input valid, status, slot, key_out, price_out, total_out, occupancy,
		output ready);
endinterface

>>> design/keyed_circular_queue.sv
// Keyed circular queue: DEPTH slots of (56-bit key, 32-bit price) in a row of cells.
// A command (enqueue, dequeue, max, total, search) is accepted in an idle cycle. A scan
// token then walks the cell row one cell per cycle collecting key match, max price, head
// entry and price sum, and the commit state applies the update and loads the result
// register. The input reopens once the commit is done, so no new command is taken
// while one is still being scanned or committed.
// The result register holds a finished beat while the next command is accepted and
// scanned; a command waits in its commit cycle only while a result is still pending.
// After reset the queue is empty and the next enqueue lands in slot 0.
// Depends on kcq_pkg, kcq_cmd_if, kcq_res_if and kcq_cell.
module keyed_circular_queue #(
	parameter int unsigned DEPTH = kcq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	kcq_cmd_if.sink     req,
	kcq_res_if.source   rsp
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [kcq_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

	kcq_pkg::state_t                 st_q, st_d;
	logic [IDX_W-1:0]                cnt_q, cnt_d;
	logic [IDX_W-1:0]                head_q, head_d;
	logic [IDX_W-1:0]                tail_q, tail_d;
	logic [CNT_W-1:0]                count_q, count_d;

	logic [kcq_pkg::CMD_W-1:0]       cmd_q;
	logic [kcq_pkg::KEY_W-1:0]       qkey_q;
	logic [kcq_pkg::PRICE_W-1:0]     qprice_q;

	logic                            rsp_valid_q;
	logic [kcq_pkg::STAT_W-1:0]      status_q;
	logic [kcq_pkg::SLOT_W-1:0]      slot_q;
	logic [kcq_pkg::KEY_W-1:0]       key_out_q;
	logic [kcq_pkg::PRICE_W-1:0]     price_out_q;
	logic [kcq_pkg::TOTAL_W-1:0]     total_out_q;
	logic [kcq_pkg::OCC_W-1:0]       occ_q;

	logic                            in_fire;
	logic                            done_go;
	logic                            pick_mode;
	logic                            enq_ok;
	logic                            deq_ok;
	logic [IDX_W-1:0]                new_tail;
	logic [IDX_W-1:0]                head_inc;
	logic [IDX_W-1:0]                tail_inc;
	logic [DEPTH-1:0]                wr_vec;
	logic [DEPTH-1:0]                clr_vec;
	logic [DEPTH-1:0]                pick_vec;

	kcq_pkg::status_t                r_status;
	logic [kcq_pkg::SLOT_W-1:0]      r_slot;
	logic [kcq_pkg::KEY_W-1:0]       r_key;
	logic [kcq_pkg::PRICE_W-1:0]     r_price;
	logic [kcq_pkg::TOTAL_W-1:0]     r_total;

	kcq_pkg::scan_t                  tok [DEPTH+1];
	kcq_pkg::scan_t                  tok_last;

	assign req.ready = (st_q == kcq_pkg::ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign done_go   = (st_q == kcq_pkg::ST_DONE) && (!rsp_valid_q || rsp.ready);
	assign pick_mode = (kcq_pkg::cmd_t'(cmd_q) == kcq_pkg::CMD_DEQ);
	assign tok_last  = tok[DEPTH];
	assign tok[0]    = '0;

	assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign new_tail = (count_q == '0) ? '0 : tail_inc;

	// Cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign wr_vec[i]   = enq_ok && (new_tail == IDX_W'(i));
		assign clr_vec[i]  = deq_ok && (head_q == IDX_W'(i));
		assign pick_vec[i] = pick_mode && (head_q == IDX_W'(i));

		kcq_cell #(
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (wr_vec[i]),
			.clr_en    (clr_vec[i]),
			.wr_key    (qkey_q),
			.wr_price  (qprice_q),
			.query_key (qkey_q),
			.pick_mode (pick_mode),
			.pick_hit  (pick_vec[i]),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1])
		);
	end

	// Sequencer and command decode
	always_comb begin
		st_d     = st_q;
		cnt_d    = cnt_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		enq_ok   = 1'b0;
		deq_ok   = 1'b0;
		r_status = kcq_pkg::STS_OK;
		r_slot   = '0;
		r_key    = '0;
		r_price  = '0;
		r_total  = '0;

		case (kcq_pkg::cmd_t'(cmd_q))
			kcq_pkg::CMD_ENQ: begin
				if (count_q == CNT_W'(DEPTH)) begin
					r_status = kcq_pkg::STS_FULL;
				end else if (tok_last.found) begin
					r_status = kcq_pkg::STS_DUP;
				end else begin
					enq_ok = done_go;
					r_slot = kcq_pkg::SLOT_W'(new_tail);
				end
			end
			kcq_pkg::CMD_DEQ: begin
				if (count_q == '0) begin
					r_status = kcq_pkg::STS_EMPTY;
				end else begin
					deq_ok  = done_go;
					r_slot  = kcq_pkg::SLOT_W'(head_q);
					r_key   = tok_last.best_key;
					r_price = tok_last.best_price;
				end
			end
			kcq_pkg::CMD_MAX: begin
				if (!tok_last.best_vld) begin
					r_status = kcq_pkg::STS_EMPTY;
				end else begin
					r_slot  = kcq_pkg::SLOT_W'(tok_last.best_idx);
					r_key   = tok_last.best_key;
					r_price = tok_last.best_price;
				end
			end
			kcq_pkg::CMD_TOT: begin
				if (count_q == '0) begin
					r_status = kcq_pkg::STS_EMPTY;
				end else if (tok_last.sum > kcq_pkg::SUM_W'(TOTAL_MAX)) begin
					r_total = TOTAL_MAX;
				end else begin
					r_total = tok_last.sum[kcq_pkg::TOTAL_W-1:0];
				end
			end
			kcq_pkg::CMD_SRCH: begin
				if (tok_last.found) begin
					r_slot = kcq_pkg::SLOT_W'(tok_last.found_idx);
				end else begin
					r_status = kcq_pkg::STS_NONE;
				end
			end
			default: begin
				r_status = kcq_pkg::STS_OK;
			end
		endcase

		// Pointer and count updates on commit
		if (enq_ok) begin
			tail_d  = new_tail;
			count_d = count_q + 1'b1;
			if (count_q == '0) begin
				head_d = '0;
			end
		end
		if (deq_ok) begin
			count_d = count_q - 1'b1;
			if (count_q == CNT_W'(1)) begin
				head_d = '0;
				tail_d = '0;
			end else begin
				head_d = head_inc;
			end
		end

		case (st_q)
			kcq_pkg::ST_IDLE: begin
				if (in_fire) begin
					st_d  = kcq_pkg::ST_SCAN;
					cnt_d = '0;
				end
			end
			kcq_pkg::ST_SCAN: begin
				if (cnt_q == IDX_W'(DEPTH - 1)) begin
					st_d = kcq_pkg::ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			kcq_pkg::ST_DONE: begin
				if (done_go) begin
					st_d = kcq_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = kcq_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= kcq_pkg::ST_IDLE;
			cnt_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			st_q    <= st_d;
			cnt_q   <= cnt_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// Captured command beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q    <= req.command;
			qkey_q   <= req.key_in;
			qprice_q <= req.price_in;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			status_q    <= r_status;
			slot_q      <= r_slot;
			key_out_q   <= r_key;
			price_out_q <= r_price;
			total_out_q <= r_total;
			occ_q       <= kcq_pkg::OCC_W'(count_d);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.slot      = slot_q;
	assign rsp.key_out   = key_out_q;
	assign rsp.price_out = price_out_q;
	assign rsp.total_out = total_out_q;
	assign rsp.occupancy = occ_q;

endmodule

>>> design/kcq_cell.sv
// kcq_cell: one queue slot (key, price, valid) plus one stage of the scan
// token chain. Depends on kcq_pkg.
module kcq_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic                          clr_en,
	input  logic [kcq_pkg::KEY_W-1:0]     wr_key,
	input  logic [kcq_pkg::PRICE_W-1:0]   wr_price,
	input  logic [kcq_pkg::KEY_W-1:0]     query_key,
	input  logic                          pick_mode,
	input  logic                          pick_hit,
	input  kcq_pkg::scan_t                tok_in,
	output kcq_pkg::scan_t                tok_out
);

	logic                          valid_q;
	logic [kcq_pkg::KEY_W-1:0]     key_q;
	logic [kcq_pkg::PRICE_W-1:0]   price_q;
	kcq_pkg::scan_t                tok_d;
	kcq_pkg::scan_t                tok_q;
	logic                          take_best;

	// Occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end else if (clr_en) begin
			valid_q <= 1'b0;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q   <= wr_key;
			price_q <= wr_price;
		end
	end

	// Fold this slot into the passing token
	always_comb begin
		tok_d = tok_in;
		if (pick_mode) begin
			take_best = pick_hit;
		end else begin
			take_best = valid_q && (!tok_in.best_vld || (price_q > tok_in.best_price));
		end
		if (valid_q) begin
			tok_d.sum = tok_in.sum + kcq_pkg::SUM_W'(price_q);
		end
		if (valid_q && !tok_in.found && (key_q == query_key)) begin
			tok_d.found     = 1'b1;
			tok_d.found_idx = kcq_pkg::TIDX_W'(IDX);
		end
		if (take_best) begin
			tok_d.best_vld   = 1'b1;
			tok_d.best_idx   = kcq_pkg::TIDX_W'(IDX);
			tok_d.best_key   = key_q;
			tok_d.best_price = price_q;
		end
	end

	// Token stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule
